// ----- sv/affine_2d_matrix_accumulator_core_assert.svh -----
// Assertion shorthands shared by the checkers of the matrix accumulator.
`ifndef AFFINE_2D_MATRIX_ACCUMULATOR_CORE_ASSERT_SVH
`define AFFINE_2D_MATRIX_ACCUMULATOR_CORE_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define AFF2D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define AFF2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/aff2d_acc_pkg.sv -----
package aff2d_acc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int IN_DATA_W  = 272;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 288;
  localparam int ELEM_W     = 32;
  localparam int NUM_ELEMS  = 9;
  localparam int IDX_W      = $clog2(NUM_ELEMS);
  localparam int STEP_W     = 4;

  localparam logic [2:0] CMD_IDENTITY  = 3'd0;
  localparam logic [2:0] CMD_TRANSLATE = 3'd1;
  localparam logic [2:0] CMD_ROTATE    = 3'd2;
  localparam logic [2:0] CMD_SCALE     = 3'd3;
  localparam logic [2:0] CMD_LOAD      = 3'd4;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_IT_W  = $clog2(CORDIC_STEPS);
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef enum logic [2:0] {
    COEF_X   = 3'd0,
    COEF_Y   = 3'd1,
    COEF_C   = 3'd2,
    COEF_S   = 3'd3,
    COEF_ONE = 3'd4
  } coef_sel_t;

  typedef struct packed {
    logic [IDX_W-1:0] src;
    coef_sel_t        coef;
    logic             neg;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] dest;
    logic             fin;
  } step_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] dest;
  } term_ctl_t;

  function automatic step_t mk(input logic [IDX_W-1:0] src, input coef_sel_t coef,
                               input logic neg, input logic first, input logic last,
                               input logic [IDX_W-1:0] dest, input logic fin);
    step_t s;
    s.src   = src;
    s.coef  = coef;
    s.neg   = neg;
    s.first = first;
    s.last  = last;
    s.dest  = dest;
    s.fin   = fin;
    return s;
  endfunction

  // Each element that a program writes is a sum of rounded products, the others keep
  // their old value; a product by one copies the old element into the sum.
  function automatic step_t prog_step(input logic [2:0] cmd, input logic [STEP_W-1:0] idx);
    step_t s;
    s = mk(4'd0, COEF_ONE, 1'b0, 1'b1, 1'b1, 4'd0, 1'b1);
    case (cmd)
      CMD_TRANSLATE: begin
        case (idx)
          4'd0:    s = mk(4'd0, COEF_X,   1'b0, 1'b1, 1'b0, 4'd6, 1'b0);
          4'd1:    s = mk(4'd3, COEF_Y,   1'b0, 1'b0, 1'b0, 4'd6, 1'b0);
          4'd2:    s = mk(4'd6, COEF_ONE, 1'b0, 1'b0, 1'b1, 4'd6, 1'b0);
          4'd3:    s = mk(4'd1, COEF_X,   1'b0, 1'b1, 1'b0, 4'd7, 1'b0);
          4'd4:    s = mk(4'd4, COEF_Y,   1'b0, 1'b0, 1'b0, 4'd7, 1'b0);
          4'd5:    s = mk(4'd7, COEF_ONE, 1'b0, 1'b0, 1'b1, 4'd7, 1'b0);
          4'd6:    s = mk(4'd2, COEF_X,   1'b0, 1'b1, 1'b0, 4'd8, 1'b0);
          4'd7:    s = mk(4'd5, COEF_Y,   1'b0, 1'b0, 1'b0, 4'd8, 1'b0);
          default: s = mk(4'd8, COEF_ONE, 1'b0, 1'b0, 1'b1, 4'd8, 1'b1);
        endcase
      end
      CMD_ROTATE: begin
        case (idx)
          4'd0:    s = mk(4'd0, COEF_C, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0);
          4'd1:    s = mk(4'd3, COEF_S, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0);
          4'd2:    s = mk(4'd3, COEF_C, 1'b0, 1'b1, 1'b0, 4'd3, 1'b0);
          4'd3:    s = mk(4'd0, COEF_S, 1'b1, 1'b0, 1'b1, 4'd3, 1'b0);
          4'd4:    s = mk(4'd1, COEF_C, 1'b0, 1'b1, 1'b0, 4'd1, 1'b0);
          4'd5:    s = mk(4'd4, COEF_S, 1'b0, 1'b0, 1'b1, 4'd1, 1'b0);
          4'd6:    s = mk(4'd4, COEF_C, 1'b0, 1'b1, 1'b0, 4'd4, 1'b0);
          4'd7:    s = mk(4'd1, COEF_S, 1'b1, 1'b0, 1'b1, 4'd4, 1'b0);
          4'd8:    s = mk(4'd2, COEF_C, 1'b0, 1'b1, 1'b0, 4'd2, 1'b0);
          4'd9:    s = mk(4'd5, COEF_S, 1'b0, 1'b0, 1'b1, 4'd2, 1'b0);
          4'd10:   s = mk(4'd5, COEF_C, 1'b0, 1'b1, 1'b0, 4'd5, 1'b0);
          default: s = mk(4'd2, COEF_S, 1'b1, 1'b0, 1'b1, 4'd5, 1'b1);
        endcase
      end
      CMD_SCALE: begin
        case (idx)
          4'd0:    s = mk(4'd0, COEF_X, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0);
          4'd1:    s = mk(4'd3, COEF_Y, 1'b0, 1'b1, 1'b1, 4'd3, 1'b0);
          4'd2:    s = mk(4'd1, COEF_X, 1'b0, 1'b1, 1'b1, 4'd1, 1'b0);
          4'd3:    s = mk(4'd4, COEF_Y, 1'b0, 1'b1, 1'b1, 4'd4, 1'b0);
          4'd4:    s = mk(4'd2, COEF_X, 1'b0, 1'b1, 1'b1, 4'd2, 1'b0);
          default: s = mk(4'd5, COEF_Y, 1'b0, 1'b1, 1'b1, 4'd5, 1'b1);
        endcase
      end
      default: s = mk(4'd0, COEF_ONE, 1'b0, 1'b1, 1'b1, 4'd0, 1'b1);
    endcase
    return s;
  endfunction

endpackage

// ----- sv/affine_2d_matrix_accumulator_core.sv -----
// Channel | Dir | Ports                        | Contents
// in      | in  | in_tvalid/tready/tdata/tuser | one command with its operands
// out     | out | out_tvalid/tready/tdata/tuser| whole matrix after the command
//
// Identity, load and unused commands go straight from idle to the done state.
// Scale and translate make one pass per product through the shared multiplier, then
// a three-stage round, accumulate and saturate drain.
// Rotate first runs 30 CORDIC iterations, then 12 multiplier passes.
// in_tready is high only while idle; a finished result waits in the result register.
// Reset is synchronous and loads the identity matrix; no clearing pass is needed.
module affine_2d_matrix_accumulator_core #(
  parameter int FRAC_BITS  = aff2d_acc_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = aff2d_acc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // x_amount, y_amount, angle, load_x_scale, load_x_skew, load_y_skew,
  // load_y_scale, load_x_shift, load_y_shift
  input  logic [aff2d_acc_pkg::IN_DATA_W-1:0]   in_tdata,
  // command
  input  logic [aff2d_acc_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // element_0 .. element_8
  output logic [aff2d_acc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // overflow
  output logic                                  out_tuser
);

  localparam int CW     = aff2d_acc_pkg::CORDIC_W;
  localparam int ACC_W  = 66 - FRAC_BITS;
  localparam int CS_SHIFT = aff2d_acc_pkg::CORDIC_FRAC - FRAC_BITS;
  localparam logic signed [CW-1:0] CS_HALF = CW'((64'd1 << CS_SHIFT) >> 1);
  localparam logic signed [63:0] FRAC_HALF = 64'((64'd1 << FRAC_BITS) >> 1);
  localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CORDIC = 6'b000010,
    ST_SINCOS = 6'b000100,
    ST_RUN    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] m_r   [aff2d_acc_pkg::NUM_ELEMS];
  logic signed [31:0] m_nxt [aff2d_acc_pkg::NUM_ELEMS];
  logic signed [31:0] res_r   [aff2d_acc_pkg::NUM_ELEMS];
  logic signed [31:0] res_nxt [aff2d_acc_pkg::NUM_ELEMS];
  logic signed [31:0] ident_w [aff2d_acc_pkg::NUM_ELEMS];

  logic [2:0] cmd_r, cmd_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt, c_r, c_nxt, s_r, s_nxt;
  logic [aff2d_acc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [aff2d_acc_pkg::CORDIC_IT_W-1:0] it_r, it_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [1:0] quad_r, quad_nxt;

  aff2d_acc_pkg::term_ctl_t p_ctl_r, p_ctl_nxt, r_ctl_r, r_ctl_nxt, a_ctl_r, a_ctl_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] rnd_r, rnd_nxt, acc_r, acc_nxt, acc_base;
  logic ov_r, ov_nxt, out_tvalid_r, out_tvalid_nxt, out_ovf_r, out_ovf_nxt;

  aff2d_acc_pkg::step_t stp;
  logic signed [31:0] mul_a, mul_b, sat_val;
  logic sat_ovf;
  logic in_acc;
  logic [31:0] phase, quad_sum, rest;
  logic [1:0] quad_w;
  logic signed [CW-1:0] dx, dy, at, c_raw, s_raw, c_rnd, s_rnd;
  logic signed [63:0] rnd_full;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_ovf_r;

  always_comb begin
    for (int k = 0; k < aff2d_acc_pkg::NUM_ELEMS; k++) begin
      out_tdata[32*k +: 32] = m_r[k];
      ident_w[k] = (k == 0 || k == 4 || k == 8) ? ONE_Q : 32'sd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    res_nxt   = res_r;
    cmd_nxt   = cmd_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    c_nxt     = c_r;
    s_nxt     = s_r;
    step_nxt  = step_r;
    it_nxt    = it_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    quad_nxt  = quad_r;
    ov_nxt    = ov_r;
    out_ovf_nxt    = out_ovf_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    // Angle to quadrant and residual phase in units of 2^-32 turn.
    phase    = (32'(in_tdata[79:64]) & ANGLE_MASK) << (32 - ANGLE_BITS);
    quad_sum = phase + 32'h2000_0000;
    quad_w   = quad_sum[31:30];
    rest     = phase - {quad_w, 30'd0};

    // One CORDIC micro-rotation.
    dx = cy_r >>> it_r;
    dy = cx_r >>> it_r;
    at = CW'(aff2d_acc_pkg::ATAN_TURNS[it_r]);

    case (quad_r)
      2'd0:    begin c_raw = cx_r;  s_raw = cy_r;  end
      2'd1:    begin c_raw = -cy_r; s_raw = cx_r;  end
      2'd2:    begin c_raw = -cx_r; s_raw = -cy_r; end
      default: begin c_raw = cy_r;  s_raw = -cx_r; end
    endcase
    c_rnd = (c_raw + CS_HALF) >>> CS_SHIFT;
    s_rnd = (s_raw + CS_HALF) >>> CS_SHIFT;

    // Shared multiplier, one product per cycle.
    stp = aff2d_acc_pkg::prog_step(cmd_r, step_r);
    case (stp.coef)
      aff2d_acc_pkg::COEF_X: mul_a = x_r;
      aff2d_acc_pkg::COEF_Y: mul_a = y_r;
      aff2d_acc_pkg::COEF_C: mul_a = c_r;
      aff2d_acc_pkg::COEF_S: mul_a = s_r;
      default:               mul_a = ONE_Q;
    endcase
    mul_b    = m_r[stp.src];
    prod_nxt = 64'(mul_a) * 64'(mul_b);

    p_ctl_nxt = '0;
    r_ctl_nxt = p_ctl_r;
    a_ctl_nxt = r_ctl_r;

    rnd_full = (prod_r + FRAC_HALF) >>> FRAC_BITS;
    rnd_nxt  = ACC_W'(rnd_full);

    acc_base = r_ctl_r.first ? '0 : acc_r;
    acc_nxt  = acc_r;
    if (r_ctl_r.vld) begin
      acc_nxt = acc_base + (r_ctl_r.neg ? -rnd_r : rnd_r);
    end

    sat_ovf = (acc_r > SAT_MAX) || (acc_r < SAT_MIN);
    if (acc_r > SAT_MAX) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (acc_r < SAT_MIN) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = acc_r[31:0];
    end
    if (a_ctl_r.vld && a_ctl_r.last) begin
      res_nxt[a_ctl_r.dest] = sat_val;
      ov_nxt = ov_r | sat_ovf;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_tuser;
          x_nxt    = in_tdata[31:0];
          y_nxt    = in_tdata[63:32];
          step_nxt = '0;
          it_nxt   = '0;
          cx_nxt   = aff2d_acc_pkg::CORDIC_GAIN;
          cy_nxt   = '0;
          cz_nxt   = CW'(signed'(rest));
          quad_nxt = quad_w;
          ov_nxt   = 1'b0;
          res_nxt  = m_r;
          case (in_tuser)
            aff2d_acc_pkg::CMD_IDENTITY: begin
              res_nxt   = ident_w;
              state_nxt = ST_DONE;
            end
            aff2d_acc_pkg::CMD_TRANSLATE: state_nxt = ST_RUN;
            aff2d_acc_pkg::CMD_SCALE:     state_nxt = ST_RUN;
            aff2d_acc_pkg::CMD_ROTATE:    state_nxt = ST_CORDIC;
            aff2d_acc_pkg::CMD_LOAD: begin
              res_nxt[0] = in_tdata[111:80];
              res_nxt[1] = in_tdata[143:112];
              res_nxt[3] = in_tdata[175:144];
              res_nxt[4] = in_tdata[207:176];
              res_nxt[6] = in_tdata[239:208];
              res_nxt[7] = in_tdata[271:240];
              state_nxt  = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CORDIC: begin
        if (!cz_r[CW-1]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - at;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + at;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == aff2d_acc_pkg::CORDIC_IT_W'(aff2d_acc_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = ST_SINCOS;
        end
      end
      ST_SINCOS: begin
        c_nxt     = c_rnd[31:0];
        s_nxt     = s_rnd[31:0];
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        p_ctl_nxt.vld   = 1'b1;
        p_ctl_nxt.neg   = stp.neg;
        p_ctl_nxt.first = stp.first;
        p_ctl_nxt.last  = stp.last;
        p_ctl_nxt.dest  = stp.dest;
        step_nxt        = step_r + 1'b1;
        if (stp.fin) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p_ctl_r.vld && !r_ctl_r.vld && !a_ctl_r.vld) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          m_nxt          = res_r;
          out_tvalid_nxt = 1'b1;
          out_ovf_nxt    = ov_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      p_ctl_r      <= '0;
      r_ctl_r      <= '0;
      a_ctl_r      <= '0;
      step_r       <= '0;
      it_r         <= '0;
      m_r          <= ident_w;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      p_ctl_r      <= p_ctl_nxt;
      r_ctl_r      <= r_ctl_nxt;
      a_ctl_r      <= a_ctl_nxt;
      step_r       <= step_nxt;
      it_r         <= it_nxt;
      m_r          <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    cmd_r     <= cmd_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    c_r       <= c_nxt;
    s_r       <= s_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cz_r      <= cz_nxt;
    quad_r    <= quad_nxt;
    prod_r    <= prod_nxt;
    rnd_r     <= rnd_nxt;
    acc_r     <= acc_nxt;
    ov_r      <= ov_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule

// ----- sv/aff2d_acc_chk.sv -----
`include "affine_2d_matrix_accumulator_core_assert.svh"

module aff2d_acc_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [aff2d_acc_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic [aff2d_acc_pkg::IN_USER_W-1:0]   in_tuser,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [aff2d_acc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                                  out_tuser
);

  // A stalled result holds.
  `AFF2D_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Every command leaves the block busy in the cycle after its transfer.
  `AFF2D_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after a transfer")

  // A new result appears only as the block returns to idle.
  `AFF2D_ASSERT_SAME(a_result_when_idle, $rose(out_tvalid), in_tready, "result appeared while busy")

  // Identity into a free output gives the identity matrix, by way of the done state.
  `AFF2D_ASSERT_SAME(a_identity, $past(rst_n, 2) && $past(rst_n) && $past(in_tvalid && in_tready && !out_tvalid && in_tuser == aff2d_acc_pkg::CMD_IDENTITY, 2), out_tvalid && out_tuser == 1'b0 && out_tdata[31:0] != 32'd0 && out_tdata[31:0] == out_tdata[159:128] && out_tdata[31:0] == out_tdata[287:256] && out_tdata[127:32] == 96'd0 && out_tdata[255:160] == 96'd0, "identity result wrong")

  // Load into a free output shows the loaded scale and skew, by way of the done state.
  `AFF2D_ASSERT_SAME(a_load, $past(rst_n, 2) && $past(rst_n) && $past(in_tvalid && in_tready && !out_tvalid && in_tuser == aff2d_acc_pkg::CMD_LOAD, 2), out_tvalid && out_tuser == 1'b0 && out_tdata[31:0] == $past(in_tdata[111:80], 2) && out_tdata[63:32] == $past(in_tdata[143:112], 2), "load result wrong")

endmodule

bind affine_2d_matrix_accumulator_core aff2d_acc_chk u_aff2d_acc_chk (.*);

// ----- bench/testbench.sv -----
module testbench;

  localparam int IN_DATA_W  = aff2d_acc_pkg::IN_DATA_W;
  localparam int IN_USER_W  = aff2d_acc_pkg::IN_USER_W;
  localparam int OUT_DATA_W = aff2d_acc_pkg::OUT_DATA_W;
  localparam int ELEM_W     = aff2d_acc_pkg::ELEM_W;
  localparam int NUM_ELEMS  = aff2d_acc_pkg::NUM_ELEMS;

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int QFRAC          = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_PER_PHASE = 488;

  localparam longint SAT_HI   = 2147483647;
  localparam longint SAT_LO   = -SAT_HI - 1;
  localparam longint CORDIC_K = 652032874;
  localparam longint ARC_TURNS [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct packed {
    logic [31:0] y_shift;
    logic [31:0] x_shift;
    logic [31:0] y_scale;
    logic [31:0] y_skew;
    logic [31:0] x_skew;
    logic [31:0] x_scale;
    logic [15:0] angle;
    logic [31:0] y_amt;
    logic [31:0] x_amt;
  } mat_ops_t;

  typedef struct {
    logic [2:0]  cmd;
    mat_ops_t    ops;
    bit          wait_empty;
    int unsigned gap_pct;
    int unsigned stall_pct;
  } mat_cmd_t;

  typedef struct {
    logic [OUT_DATA_W-1:0] elems;
    logic                  ovf;
  } mat_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  mat_cmd_t          cmd_backlog[$];
  mat_result_t       matrix_expected[$];
  mat_cmd_t          cur_cmd;
  logic signed [31:0] model_mat [NUM_ELEMS];
  int unsigned       stall_pct = 0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  affine_2d_matrix_accumulator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void load_unit_matrix();
    for (int k = 0; k < NUM_ELEMS; k++)
      model_mat[k] = '0;
    model_mat[0] = 32'sh0001_0000;
    model_mat[4] = 32'sh0001_0000;
    model_mat[8] = 32'sh0001_0000;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    return (a * b + (longint'(1) << (QFRAC - 1))) >>> QFRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v, inout bit ov);
    if (v > SAT_HI) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < SAT_LO) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void cordic_sincos(input logic [15:0] ang, output longint c,
                                        output longint s);
    logic [31:0] phase;
    logic [31:0] rest;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy, cx, sx;
    phase = {ang, 16'h0000};
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    rest  = phase - {quad, 30'b0};
    z     = longint'($signed(rest));
    x     = CORDIC_K;
    y     = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURNS[i];
      end
    end
    case (quad)
      2'd0: begin
        cx = x;
        sx = y;
      end
      2'd1: begin
        cx = -y;
        sx = x;
      end
      2'd2: begin
        cx = -x;
        sx = -y;
      end
      default: begin
        cx = y;
        sx = -x;
      end
    endcase
    c = (cx + (longint'(1) << 13)) >>> 14;
    s = (sx + (longint'(1) << 13)) >>> 14;
  endfunction

  function automatic mat_result_t advance_matrix(input logic [2:0] cmd, input mat_ops_t o);
    mat_result_t r;
    bit          ov;
    longint      x, y, c, s, a, b;
    ov = 1'b0;
    x  = longint'($signed(o.x_amt));
    y  = longint'($signed(o.y_amt));
    case (cmd)
      aff2d_acc_pkg::CMD_IDENTITY: load_unit_matrix();
      aff2d_acc_pkg::CMD_TRANSLATE: begin
        for (int k = 0; k < 3; k++)
          model_mat[6+k] = clamp32(q_mul(x, model_mat[k]) + q_mul(y, model_mat[3+k]) +
                                   model_mat[6+k], ov);
      end
      aff2d_acc_pkg::CMD_ROTATE: begin
        cordic_sincos(o.angle, c, s);
        for (int k = 0; k < 3; k++) begin
          a = model_mat[k];
          b = model_mat[3+k];
          model_mat[k]   = clamp32(q_mul(c, a) + q_mul(s, b), ov);
          model_mat[3+k] = clamp32(q_mul(c, b) - q_mul(s, a), ov);
        end
      end
      aff2d_acc_pkg::CMD_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          model_mat[k]   = clamp32(q_mul(x, model_mat[k]), ov);
          model_mat[3+k] = clamp32(q_mul(y, model_mat[3+k]), ov);
        end
      end
      aff2d_acc_pkg::CMD_LOAD: begin
        model_mat[0] = o.x_scale;
        model_mat[1] = o.x_skew;
        model_mat[3] = o.y_skew;
        model_mat[4] = o.y_scale;
        model_mat[6] = o.x_shift;
        model_mat[7] = o.y_shift;
      end
      default: ;
    endcase
    for (int k = 0; k < NUM_ELEMS; k++)
      r.elems[ELEM_W*k +: ELEM_W] = model_mat[k];
    r.ovf = ov;
    return r;
  endfunction

  function automatic logic [31:0] rand_q();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)
      return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    if (pick < 70)
      return 32'h0001_0000 + $urandom_range(32'h2000) - 32'h1000;
    if (pick < 90)
      return $urandom;
    pick = $urandom_range(3);
    if (pick == 0)
      return 32'h7FFF_FFFF;
    if (pick == 1)
      return 32'h8000_0000;
    if (pick == 2)
      return 32'h0000_0000;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic mat_ops_t rand_ops();
    mat_ops_t o;
    o.x_amt   = rand_q();
    o.y_amt   = rand_q();
    o.angle   = 16'($urandom);
    o.x_scale = rand_q();
    o.x_skew  = rand_q();
    o.y_skew  = rand_q();
    o.y_scale = rand_q();
    o.x_shift = rand_q();
    o.y_shift = rand_q();
    return o;
  endfunction

  function automatic logic [2:0] rand_cmd();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10)
      return aff2d_acc_pkg::CMD_IDENTITY;
    if (pick < 35)
      return aff2d_acc_pkg::CMD_TRANSLATE;
    if (pick < 60)
      return aff2d_acc_pkg::CMD_ROTATE;
    if (pick < 80)
      return aff2d_acc_pkg::CMD_SCALE;
    if (pick < 95)
      return aff2d_acc_pkg::CMD_LOAD;
    pick = $urandom_range(2);
    if (pick == 0)
      return CMD_SPARE_5;
    if (pick == 1)
      return CMD_SPARE_6;
    return CMD_SPARE_7;
  endfunction

  function automatic void push_cmd(input logic [2:0] cmd, input mat_ops_t o, input bit drain,
                                   input int unsigned gap, input int unsigned stall);
    mat_cmd_t item;
    item.cmd        = cmd;
    item.ops        = o;
    item.wait_empty = drain;
    item.gap_pct    = gap;
    item.stall_pct  = stall;
    cmd_backlog.push_back(item);
  endfunction

  function automatic mat_ops_t with_amounts(input logic [31:0] x, input logic [31:0] y);
    mat_ops_t o;
    o       = rand_ops();
    o.x_amt = x;
    o.y_amt = y;
    return o;
  endfunction

  function automatic mat_ops_t with_angle(input logic [15:0] ang);
    mat_ops_t o;
    o       = rand_ops();
    o.angle = ang;
    return o;
  endfunction

  function automatic mat_ops_t with_loads(input logic [31:0] v);
    mat_ops_t o;
    o         = rand_ops();
    o.x_scale = v;
    o.x_skew  = v;
    o.y_skew  = v;
    o.y_scale = v;
    o.x_shift = v;
    o.y_shift = v;
    return o;
  endfunction

  // A new command is offered only once the previous transfer has completed.
  always @(posedge clk) begin
    bit next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        matrix_expected.push_back(advance_matrix(cur_cmd.cmd, cur_cmd.ops));
        next_valid = 1'b0;
      end
      if (!next_valid && cmd_backlog.size() != 0) begin
        if (!(cmd_backlog[0].wait_empty && matrix_expected.size() != 0) &&
            $urandom_range(99) >= cmd_backlog[0].gap_pct) begin
          cur_cmd   = cmd_backlog.pop_front();
          stall_pct = cur_cmd.stall_pct;
          in_tdata  <= cur_cmd.ops;
          in_tuser  <= cur_cmd.cmd;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  always @(posedge clk) begin
    mat_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (matrix_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h overflow %b",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = matrix_expected.pop_front();
          for (int k = 0; k < NUM_ELEMS; k++) begin
            if (out_tdata[ELEM_W*k +: ELEM_W] !== want.elems[ELEM_W*k +: ELEM_W]) begin
              $display("%0t: element_%0d expected %h actual %h", $time, k,
                       want.elems[ELEM_W*k +: ELEM_W], out_tdata[ELEM_W*k +: ELEM_W]);
              mismatch_count++;
            end
          end
          if (out_tuser !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, out_tuser);
            mismatch_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned gap_of   [4];
    int unsigned stall_of [4];
    gap_of   = '{0, 49, 0, 25};
    stall_of = '{0, 0, 49, 25};
    load_unit_matrix();

    push_cmd(aff2d_acc_pkg::CMD_IDENTITY, rand_ops(), 1'b1, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'h0000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'h4000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'h8000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'hC000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'hFFFF), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'h2000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_SCALE,
             with_amounts(32'h7FFF_FFFF, 32'h8000_0000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_SCALE,
             with_amounts(32'hFFFF_0000, 32'h0000_0000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_IDENTITY, rand_ops(), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_TRANSLATE,
             with_amounts(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_TRANSLATE,
             with_amounts(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_TRANSLATE,
             with_amounts(32'h8000_0000, 32'h8000_0000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_LOAD, with_loads(32'h7FFF_FFFF), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_TRANSLATE,
             with_amounts(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_LOAD, with_loads(32'h8000_0000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_ROTATE, with_angle(16'h6000), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_SCALE,
             with_amounts(32'h8000_0000, 32'h8000_0000), 1'b0, 0, 0);
    push_cmd(CMD_SPARE_5, rand_ops(), 1'b0, 0, 0);
    push_cmd(CMD_SPARE_6, rand_ops(), 1'b0, 0, 0);
    push_cmd(CMD_SPARE_7, rand_ops(), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_LOAD, rand_ops(), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_IDENTITY, rand_ops(), 1'b0, 0, 0);
    push_cmd(aff2d_acc_pkg::CMD_SCALE,
             with_amounts(32'h0001_0000, 32'hFFFF_FFFF), 1'b0, 0, 0);

    for (int p = 0; p < 4; p++)
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        push_cmd(rand_cmd(), rand_ops(), (n == 0) || ($urandom_range(49) == 0),
                 gap_of[p], stall_of[p]);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_backlog.size() != 0 || in_tvalid || matrix_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
